// ===== rtl/mbps_pkg.sv =====
`default_nettype none
package mbps_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 12;
    localparam int GRAY_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd160;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd100;

    // root of an 18-bit radicand: 9 digit steps
    localparam int SQ_W     = 18;
    localparam int SQ_STEPS = 9;
    localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]  out_x;
        logic [PIX_W-1:0]  out_y;
        logic [GRAY_W-1:0] gray;
        logic              clear_area;
    } pix_out_t;

endpackage
`default_nettype wire

// ===== rtl/mbps_stream_if.sv =====
`default_nettype none
interface mbps_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mbps_div_cell.sv =====
`default_nettype none
// one restoring division step: shifts in the next dividend bit, emits one quotient bit
module mbps_div_cell #(
    parameter int N  = 40,
    parameter int DW = 13
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [N-1:0]  in_word,
    input  wire logic [DW-1:0] in_div,
    output logic               out_valid,
    output logic [DW-1:0]      out_rem,
    output logic [N-1:0]       out_word,
    output logic [DW-1:0]      out_div
);
    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [N-1:0]  word_reg, word_next;
    logic [DW-1:0] div_reg;
    logic [DW:0]   trial;
    logic          ge;

    always_comb
    begin
        trial     = {in_rem, in_word[N-1]};
        ge        = trial >= {1'b0, in_div};
        rem_next  = ge ? DW'(trial - {1'b0, in_div}) : trial[DW-1:0];
        word_next = {in_word[N-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        word_reg <= word_next;
        div_reg  <= in_div;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_word  = word_reg;
    assign out_div   = div_reg;
endmodule
`default_nettype wire

// ===== rtl/mbps_div_chain.sv =====
`default_nettype none
module mbps_div_chain #(
    parameter int N  = 40,
    parameter int DW = 13
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [N-1:0]  in_dividend,
    input  wire logic [DW-1:0] in_div,
    output logic               out_valid,
    output logic [N-1:0]       out_quot
);
    logic          v   [N+1];
    logic [DW-1:0] rem [N+1];
    logic [N-1:0]  wrd [N+1];
    logic [DW-1:0] dv  [N+1];

    assign v[0]   = in_valid;
    assign rem[0] = '0;
    assign wrd[0] = in_dividend;
    assign dv[0]  = in_div;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        mbps_div_cell #(.N(N), .DW(DW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v[i]),
            .in_rem   (rem[i]),
            .in_word  (wrd[i]),
            .in_div   (dv[i]),
            .out_valid(v[i+1]),
            .out_rem  (rem[i+1]),
            .out_word (wrd[i+1]),
            .out_div  (dv[i+1])
        );
    end

    assign out_valid = v[N];
    assign out_quot  = wrd[N];
endmodule
`default_nettype wire

// ===== rtl/mandelbrot_pixel_shader.sv =====
`default_nettype none
// channel    dir  payload                             beat when
// pix_in     in   pixel_x, pixel_y                    valid && ready
// pix_out    out  out_x, out_y, gray, clear_area      valid && ready
// cfg        in   cfg_index, cfg_data                 cfg_we
//
// One pixel at a time: an accept step, the divider chain, the divide by 5 (reciprocal multiply,
// 12 bits a cycle), a multiply and an update per iteration, an escape check, then a last multiply
// and the root unless the check already ends the pixel, and a handoff.
// Default parameters allow at most 100 iterations.
// rst_n clears control state and loads the register reset values.
// A result waiting on pix_out does not block the next pixel from entering; only the
// handoff of the next result waits for it.
module mandelbrot_pixel_shader #(
    parameter int MAX_ITER   = 100,
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbps_pkg::CFG_W-1:0]     cfg_data,
    mbps_stream_if.sink                        pix_in,
    mbps_stream_if.source                      pix_out
);
    import mbps_pkg::*;

    localparam int N   = COORD_BITS + FRAC_BITS;
    localparam int NW  = N + 5;
    localparam int ZW  = (N + 3 > FRAC_BITS + 10) ? N + 3 : FRAC_BITS + 10;
    localparam int MW  = FRAC_BITS + 4;
    localparam int PW  = 2 * MW;
    localparam int QW  = PW - FRAC_BITS;
    localparam int CMX = (NW > MAX_ITER) ? NW : MAX_ITER;
    localparam int CW  = $clog2(CMX + 1);

    // floor(n/5) as (n * ceil(2^K/5)) >> K, exact for n below 2^NW
    localparam int D5_K  = NW + 3;
    localparam int D5_KW = D5_K + 1;
    localparam int D5_SL = 12;
    localparam int D5_S  = (NW + D5_SL) / D5_SL;
    localparam int D5_MW = D5_S * D5_SL;
    localparam int D5_PW = NW + D5_SL;
    localparam int D5_AW = NW + D5_MW;
    localparam logic [D5_K:0]    D5_POW   = {1'b1, {D5_K{1'b0}}};
    localparam logic [D5_K:0]    D5_RCP_K = (D5_POW + D5_KW'(4)) / D5_KW'(5);
    localparam logic [D5_MW-1:0] D5_RCP   = D5_MW'(D5_RCP_K);

    localparam logic signed [ZW-1:0] ONE_Q   = ZW'(1) <<< FRAC_BITS;
    localparam logic signed [ZW-1:0] THREE_Q = ZW'(3) <<< (FRAC_BITS - 2);
    localparam logic signed [ZW-1:0] LIM_Q   = ZW'(10) <<< FRAC_BITS;
    localparam logic signed [NW-1:0] HALF_Q  = NW'(1) <<< (FRAC_BITS - 1);
    localparam logic [CW-1:0]        ITER_LAST = CW'(MAX_ITER - 1);
    localparam logic [CW-1:0]        D5_LAST   = CW'(D5_S - 1);
    localparam logic [CW-1:0]        SQ_LAST   = CW'(SQ_STEPS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_D5   = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_FADD = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [CFG_W-1:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RST;
            height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                  in_beat;
    logic [PIX_W+COORD_BITS-1:0] xin_ext, yin_ext;
    logic [COORD_BITS-1:0] px_reg, py_reg;

    assign pix_in.ready = (state_reg == S_IDLE);
    assign in_beat      = pix_in.valid && pix_in.ready;
    assign xin_ext      = {COORD_BITS'(0), pix_in.data.pixel_x};
    assign yin_ext      = {COORD_BITS'(0), pix_in.data.pixel_y};

    // divider chain: x beat on accept, y beat right after
    logic             feed_y_reg;
    logic             got_x_reg;
    logic             ch_in_valid, ch_out_valid;
    logic [N-1:0]     ch_dividend, ch_quot;
    logic [CFG_W-1:0] ch_div;

    always_comb
    begin
        ch_in_valid = in_beat || feed_y_reg;
        if (feed_y_reg)
        begin
            ch_dividend = {py_reg, FRAC_BITS'(0)};
            ch_div      = (height_reg == '0) ? CFG_W'(1) : height_reg;
        end
        else
        begin
            ch_dividend = {xin_ext[COORD_BITS-1:0], FRAC_BITS'(0)};
            ch_div      = (width_reg == '0) ? CFG_W'(1) : width_reg;
        end
    end

    mbps_div_chain #(.N(N), .DW(CFG_W)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (ch_in_valid),
        .in_dividend(ch_dividend),
        .in_div     (ch_div),
        .out_valid  (ch_out_valid),
        .out_quot   (ch_quot)
    );

    // floor(n/5), reciprocal taken a slice at a time from the top
    logic signed [NW-1:0]   n9;
    logic [NW-1:0]          d5_word_reg;
    logic [D5_MW-1:0]       d5_m_reg;
    logic [D5_AW-1:0]       d5_acc_reg, d5_acc_next;
    logic [D5_PW-1:0]       d5_prod;
    logic [D5_AW-D5_K-1:0]  d5_q;
    logic                   d5_neg_reg;

    always_comb
    begin
        n9          = ((NW'(ch_quot) - HALF_Q) <<< 3) + (NW'(ch_quot) - HALF_Q);
        d5_prod     = D5_PW'(d5_word_reg) * D5_PW'(d5_m_reg[D5_MW-1 -: D5_SL]);
        d5_acc_next = (d5_acc_reg << D5_SL) + D5_AW'(d5_prod);
        d5_q        = d5_acc_reg[D5_AW-1:D5_K];
    end

    // iteration datapath
    logic signed [ZW-1:0] zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [ZW-1:0] zr_abs, zi_abs;
    logic [MW-1:0]        am, bm;
    logic [PW-1:0]        prr_reg, pii_reg, pri_reg;
    logic                 neg_ri_reg;
    logic [QW-1:0]        qrr, qii, qri;
    logic signed [ZW-1:0] sri, tr, ti, zr_next, zi_next;
    logic                 esc;
    logic                 final_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [NW-1:0] ci_nw;

    always_comb
    begin
        zr_abs  = zr_reg[ZW-1] ? -zr_reg : zr_reg;
        zi_abs  = zi_reg[ZW-1] ? -zi_reg : zi_reg;
        am      = zr_abs[MW-1:0];
        bm      = zi_abs[MW-1:0];
        qrr     = prr_reg[PW-1:FRAC_BITS];
        qii     = pii_reg[PW-1:FRAC_BITS];
        qri     = pri_reg[PW-1:FRAC_BITS]
                  + QW'(neg_ri_reg && (pri_reg[FRAC_BITS-1:0] != '0));
        sri     = neg_ri_reg ? -ZW'(qri) : ZW'(qri);
        tr      = ZW'(qrr) - ZW'(qii);
        ti      = sri <<< 1;
        zr_next = tr + cr_reg;
        zi_next = ti + ci_reg;
        esc     = (zr_next < -LIM_Q) || (zr_next > LIM_Q)
                  || (zi_next < -LIM_Q) || (zi_next > LIM_Q);
        ci_nw   = d5_neg_reg ? -NW'(d5_q) : NW'(d5_q);
    end

    // root
    logic [SQ_W-1:0]   sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [SQ_W-1:0]   sq_sum;
    logic [QW:0]       ssum;
    logic [GRAY_W-1:0] gray_reg;

    assign sq_sum = sq_r_reg + sq_bit_reg;
    assign ssum   = {1'b0, qrr} + {1'b0, qii};

    logic     out_valid_reg;
    pix_out_t out_reg;
    logic [PIX_W+COORD_BITS-1:0] xo_ext, yo_ext;

    assign xo_ext = {PIX_W'(0), px_reg};
    assign yo_ext = {PIX_W'(0), py_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_beat) state_next = S_DIV;
            S_DIV:  if (ch_out_valid && got_x_reg) state_next = S_D5;
            S_D5:   if (cnt_reg == D5_LAST) state_next = S_MUL;
            S_MUL:  state_next = final_reg ? S_FADD : S_UPD;
            S_UPD:  state_next = (esc || cnt_reg == ITER_LAST) ? S_CHK : S_MUL;
            S_CHK:
            begin
                if (zr_reg <= -ONE_Q || zr_reg >= ONE_Q
                    || zi_reg <= -ONE_Q || zi_reg >= ONE_Q)
                    state_next = S_DONE;
                else
                    state_next = S_MUL;
            end
            S_FADD: state_next = S_SQRT;
            S_SQRT: if (cnt_reg == SQ_LAST) state_next = S_DONE;
            S_DONE: if (!out_valid_reg || pix_out.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            feed_y_reg    <= 1'b0;
            got_x_reg     <= 1'b0;
            final_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            feed_y_reg <= in_beat;
            if (state_reg == S_DONE && (!out_valid_reg || pix_out.ready))
                out_valid_reg <= 1'b1;
            else if (pix_out.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    got_x_reg <= 1'b0;
                    final_reg <= 1'b0;
                    cnt_reg   <= '0;
                end
                S_DIV:  if (ch_out_valid) got_x_reg <= 1'b1;
                S_D5:   cnt_reg <= (cnt_reg == D5_LAST) ? '0 : cnt_reg + CW'(1);
                S_UPD:  cnt_reg <= cnt_reg + CW'(1);
                S_CHK:
                begin
                    final_reg <= 1'b1;
                    cnt_reg   <= '0;
                end
                S_SQRT: cnt_reg <= cnt_reg + CW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            px_reg <= xin_ext[COORD_BITS-1:0];
            py_reg <= yin_ext[COORD_BITS-1:0];
        end
        unique case (state_reg)
            S_DIV:
            begin
                if (ch_out_valid && !got_x_reg)
                    cr_reg <= (ZW'(ch_quot) - THREE_Q) <<< 1;
                if (ch_out_valid && got_x_reg)
                begin
                    d5_neg_reg  <= n9[NW-1];
                    d5_word_reg <= n9[NW-1] ? (-n9 + NW'(4)) : n9;
                    d5_m_reg    <= D5_RCP;
                    d5_acc_reg  <= '0;
                end
            end
            S_D5:
            begin
                d5_acc_reg <= d5_acc_next;
                d5_m_reg   <= d5_m_reg << D5_SL;
                zr_reg     <= '0;
                zi_reg     <= '0;
            end
            S_MUL:
            begin
                if (cnt_reg == '0 && !final_reg)
                    ci_reg <= ZW'(ci_nw);
                prr_reg    <= PW'(am) * PW'(am);
                pii_reg    <= PW'(bm) * PW'(bm);
                pri_reg    <= PW'(am) * PW'(bm);
                neg_ri_reg <= zr_reg[ZW-1] ^ zi_reg[ZW-1];
            end
            S_UPD:
            begin
                zr_reg <= zr_next;
                zi_reg <= zi_next;
            end
            S_CHK:  gray_reg <= GRAY_MAX;
            S_FADD:
            begin
                sq_v_reg   <= SQ_W'(ssum >> (FRAC_BITS - 16));
                sq_r_reg   <= '0;
                sq_bit_reg <= SQ_W'(1) << 16;
            end
            S_SQRT:
            begin
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_reg <= sq_v_reg - sq_sum;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (cnt_reg == SQ_LAST)
                    gray_reg <= ((sq_v_reg >= sq_sum ? (sq_r_reg >> 1) + sq_bit_reg
                                  : sq_r_reg >> 1) > SQ_W'(GRAY_MAX))
                                ? GRAY_MAX
                                : GRAY_W'(sq_v_reg >= sq_sum ? (sq_r_reg >> 1) + sq_bit_reg
                                          : sq_r_reg >> 1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || pix_out.ready)
                begin
                    out_reg.out_x      <= xo_ext[PIX_W-1:0];
                    out_reg.out_y      <= yo_ext[PIX_W-1:0];
                    out_reg.gray       <= gray_reg;
                    out_reg.clear_area <= (px_reg == '0) && (py_reg == '0);
                end
            end
            default: ;
        endcase
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> state_reg != S_IDLE)
        else $error("pixel accepted but sequencer stayed idle");

    a_chain_out_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        ch_out_valid |-> state_reg == S_DIV)
        else $error("divider beat outside divide phase");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> cnt_reg <= ITER_LAST)
        else $error("iteration count past limit");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished pixel not presented");
endmodule
`default_nettype wire
